FILE: rtl/lkv_pkg.sv
// Shared types and codes for the linear key/value table.
package lkv_pkg;

    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [FILL_W-1:0]   fill_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_LOOKUP = 2'd1;
    localparam opcode_t OP_REMOVE = 2'd2;

    localparam status_t ST_INSERTED    = 3'd0;
    localparam status_t ST_UPDATED     = 3'd1;
    localparam status_t ST_FULL        = 3'd2;
    localparam status_t ST_HIT         = 3'd3;
    localparam status_t ST_MISS        = 3'd4;
    localparam status_t ST_REMOVED     = 3'd5;
    localparam status_t ST_REMOVE_MISS = 3'd6;

    typedef struct packed {
        opcode_t opcode;
        word_t   key;
        word_t   value;
    } cmd_t;

    typedef struct packed {
        status_t status;
        word_t   value_out;
        word_t   any_key;
        logic    is_empty;
        fill_t   fill_count;
    } rsp_t;

    // Per-cycle control broadcast to every cell.
    typedef struct packed {
        logic capture;  // latch compare result for the accepted word
        logic ins;      // shift toward the tail, new entry enters cell 0
        logic upd;      // overwrite value in the matching cell
        logic rem;      // shift toward the head, head fills the hole
    } cell_ctrl_t;

endpackage

FILE: rtl/lkv_cell.sv
// One table slot: holds a key/value entry and its latched compare result.
module lkv_cell #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lkv_pkg::cell_ctrl_t    ctrl,
    input  logic                   occ,
    input  logic [KEY_WIDTH-1:0]   key_cmp,
    input  logic [VALUE_WIDTH-1:0] value_in,
    input  logic [KEY_WIDTH-1:0]   up_key,
    input  logic [VALUE_WIDTH-1:0] up_value,
    input  logic [KEY_WIDTH-1:0]   below_key,
    input  logic [VALUE_WIDTH-1:0] below_value,
    input  logic                   below_match,
    input  logic [KEY_WIDTH-1:0]   head_key,
    input  logic [VALUE_WIDTH-1:0] head_value,
    output logic [KEY_WIDTH-1:0]   key,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [KEY_WIDTH-1:0]   key_next,
    output logic                   match,
    output logic [VALUE_WIDTH-1:0] hit_value
);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   match_reg;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.ins)
        begin
            key_next   = up_key;
            value_next = up_value;
        end
        else if (ctrl.rem)
        begin
            // The neighbor below was removed: take the head entry instead.
            if (below_match)
            begin
                key_next   = head_key;
                value_next = head_value;
            end
            else
            begin
                key_next   = below_key;
                value_next = below_value;
            end
        end
        else if (ctrl.upd && match_reg)
        begin
            value_next = value_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            match_reg <= occ && (key_reg == key_cmp);
        end
    end

    assign key       = key_reg;
    assign value     = value_reg;
    assign match     = match_reg;
    assign hit_value = match_reg ? value_reg : '0;

endmodule

FILE: rtl/linear_key_value_table.sv
// Linear key/value table: fixed-capacity associative store kept in a row of slot cells.
// Command channel: drive cmd (opcode, key, value) and raise start; the word is taken at
// the rising edge where start is high and busy is low. Opcode insert adds or updates,
// lookup returns the stored value, remove takes the entry out; the spare code acts as lookup.
// Result channel: rsp is valid for exactly one cycle while rsp_valid is high and must be
// taken then; the receiver cannot hold it off. Every result carries the status, the
// looked-up value, the key in cell 0, the empty flag and the fill count.
// Timing: the accept edge latches a key compare in every cell at once; the next cycle
// updates the row (append, in-place update, or compaction) and loads the result register.
// busy is high for that one cycle, so no new word is taken while one executes. The result
// word is shown in the cycle after the execute cycle and is taken at the edge that ends
// it, the same edge that may take the next word.
// New entries enter at cell 0; insert shifts the row toward the tail and remove
// shifts it toward the head, refilling the removed slot with the head entry, so each cell
// only talks to its neighbors plus the head broadcast.
// Reset empties the table (fill count zero) and clears control state; slot contents are
// not cleared, since only occupied slots are ever compared or read.
module linear_key_value_table #(
    parameter int DEPTH       = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lkv_pkg::cmd_t cmd,
    output logic          rsp_valid,
    output lkv_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    lkv_pkg::cmd_t      cmd_reg;
    lkv_pkg::rsp_t      rsp_reg;
    lkv_pkg::rsp_t      rsp_next;
    logic               rsp_valid_reg;
    lkv_pkg::cell_ctrl_t ctrl;
    logic               accept;

    logic [KEY_WIDTH-1:0]   cell_key      [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_value    [DEPTH];
    logic [KEY_WIDTH-1:0]   cell_key_next [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_hit      [DEPTH];
    logic [KEY_WIDTH-1:0]   up_key        [DEPTH];
    logic [VALUE_WIDTH-1:0] up_value      [DEPTH];
    logic [KEY_WIDTH-1:0]   below_key     [DEPTH];
    logic [VALUE_WIDTH-1:0] below_value   [DEPTH];
    logic [DEPTH-1:0]       below_match;
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH-1:0]       occ;

    logic [KEY_WIDTH-1:0]   key_cmp;
    logic [KEY_WIDTH-1:0]   key_op;
    logic [VALUE_WIDTH-1:0] value_op;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic                   any_match;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign key_cmp  = KEY_WIDTH'(cmd.key);
    assign key_op   = KEY_WIDTH'(cmd_reg.key);
    assign value_op = VALUE_WIDTH'(cmd_reg.value);

    // Row of slot cells; neighbor wiring with fixed ends.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign up_key[i]   = key_op;
            assign up_value[i] = value_op;
        end
        else
        begin : g_mid
            assign up_key[i]   = cell_key[i-1];
            assign up_value[i] = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign below_key[i]   = '0;
            assign below_value[i] = '0;
            assign below_match[i] = 1'b0;
        end
        else
        begin : g_link
            assign below_key[i]   = cell_key[i+1];
            assign below_value[i] = cell_value[i+1];
            assign below_match[i] = match_vec[i+1];
        end

        lkv_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .occ         (occ[i]),
            .key_cmp     (key_cmp),
            .value_in    (value_op),
            .up_key      (up_key[i]),
            .up_value    (up_value[i]),
            .below_key   (below_key[i]),
            .below_value (below_value[i]),
            .below_match (below_match[i]),
            .head_key    (cell_key[0]),
            .head_value  (cell_value[0]),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .key_next    (cell_key_next[i]),
            .match       (match_vec[i]),
            .hit_value   (cell_hit[i])
        );
    end

    // Keys are unique, so at most one cell flags a match; merge the gated values.
    always_comb
    begin
        hit_value = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            hit_value = hit_value | cell_hit[j];
        end
    end

    assign any_match = |match_vec;

    // Decide the operation in the execute cycle and build the result word.
    always_comb
    begin
        ctrl           = '0;
        ctrl.capture   = accept;
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next         = ST_IDLE;
                rsp_next.value_out = '0;
                case (cmd_reg.opcode)
                    lkv_pkg::OP_INSERT:
                    begin
                        if (any_match)
                        begin
                            ctrl.upd        = 1'b1;
                            rsp_next.status = lkv_pkg::ST_UPDATED;
                        end
                        else if (count_reg < CNT_W'(DEPTH))
                        begin
                            ctrl.ins        = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            rsp_next.status = lkv_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            rsp_next.status = lkv_pkg::ST_FULL;
                        end
                    end
                    lkv_pkg::OP_REMOVE:
                    begin
                        if (any_match)
                        begin
                            ctrl.rem        = 1'b1;
                            count_next      = count_reg - CNT_W'(1);
                            rsp_next.status = lkv_pkg::ST_REMOVED;
                        end
                        else
                        begin
                            rsp_next.status = lkv_pkg::ST_REMOVE_MISS;
                        end
                    end
                    default:
                    begin
                        if (any_match)
                        begin
                            rsp_next.status    = lkv_pkg::ST_HIT;
                            rsp_next.value_out = lkv_pkg::word_t'(hit_value);
                        end
                        else
                        begin
                            rsp_next.status = lkv_pkg::ST_MISS;
                        end
                    end
                endcase
                // Report the key in cell 0 as it stands after this operation.
                rsp_next.any_key    = (count_next == '0) ? '0
                                      : lkv_pkg::word_t'(cell_key_next[0]);
                rsp_next.is_empty   = (count_next == '0);
                rsp_next.fill_count = lkv_pkg::fill_t'(count_next);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= (state_reg == ST_EXEC);
        end
    end

    // Hold the accepted word and the result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matched the key");

    a_rsp_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (state_reg == ST_IDLE))
        else $error("result word shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && rsp_valid_reg == 1'b0)
        else $error("accepted word did not enter the execute cycle");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.is_empty == (rsp_reg.fill_count == '0)))
        else $error("empty flag disagrees with fill count");
`endif

endmodule

FILE: tb/lkv_table_checker.sv
// Checker for the linear key/value table: tracks the table contents and compares every result.
module lkv_table_checker #(
    parameter int DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  lkv_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  lkv_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending_count
);

    lkv_pkg::word_t table_keys   [DEPTH];
    lkv_pkg::word_t table_values [DEPTH];
    int unsigned    table_fill;
    lkv_pkg::rsp_t  expected_rsp [$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        table_fill    = 0;
    end

    // Apply one accepted word to the tracked table and return the result it must produce.
    function automatic lkv_pkg::rsp_t apply_command(input lkv_pkg::cmd_t c);
        lkv_pkg::rsp_t r;
        int            slot;
        int            i;
        int unsigned   last;
        r    = '0;
        slot = -1;
        case (c.opcode)
            lkv_pkg::OP_INSERT:
            begin
                for (i = 0; i < int'(table_fill); i++)
                begin
                    if (slot < 0 && table_keys[i] == c.key)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    table_values[slot] = c.value;
                    r.status = lkv_pkg::ST_UPDATED;
                end
                else if (table_fill < DEPTH)
                begin
                    table_keys[table_fill]   = c.key;
                    table_values[table_fill] = c.value;
                    table_fill++;
                    r.status = lkv_pkg::ST_INSERTED;
                end
                else
                    r.status = lkv_pkg::ST_FULL;
            end
            lkv_pkg::OP_REMOVE:
            begin
                for (i = int'(table_fill) - 1; i >= 0; i--)
                begin
                    if (slot < 0 && table_keys[i] == c.key)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    // fill the hole with the last entry
                    last               = table_fill - 1;
                    table_keys[slot]   = table_keys[last];
                    table_values[slot] = table_values[last];
                    table_fill         = last;
                    r.status           = lkv_pkg::ST_REMOVED;
                end
                else
                    r.status = lkv_pkg::ST_REMOVE_MISS;
            end
            default:
            begin
                // lookup, and the unused code acts the same
                for (i = 0; i < int'(table_fill); i++)
                begin
                    if (slot < 0 && table_keys[i] == c.key)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    r.value_out = table_values[slot];
                    r.status    = lkv_pkg::ST_HIT;
                end
                else
                    r.status = lkv_pkg::ST_MISS;
            end
        endcase
        r.any_key    = (table_fill > 0) ? table_keys[table_fill - 1] : '0;
        r.is_empty   = (table_fill == 0);
        r.fill_count = lkv_pkg::fill_t'(table_fill);
        return r;
    endfunction

    task automatic compare_rsp(input lkv_pkg::rsp_t want, input lkv_pkg::rsp_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.value_out !== want.value_out)
        begin
            $error("value_out: expected %h, got %h", want.value_out, got.value_out);
            fail_count++;
        end
        if (got.any_key !== want.any_key)
        begin
            $error("any_key: expected %h, got %h", want.any_key, got.any_key);
            fail_count++;
        end
        if (got.is_empty !== want.is_empty)
        begin
            $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
            fail_count++;
        end
        if (got.fill_count !== want.fill_count)
        begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_fill = 0;
            expected_rsp.delete();
        end
        else
        begin
            if (rsp_valid === 1'b1)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result with no outstanding word");
                    fail_count++;
                end
                else
                    compare_rsp(expected_rsp.pop_front(), rsp);
            end
            if (start && busy === 1'b0)
                expected_rsp.push_back(apply_command(cmd));
        end
        pending_count = expected_rsp.size();
    end

endmodule

FILE: tb/linear_key_value_table_test.sv
// Testbench top for the linear key/value table: stimulus, watchdog and verdict.
//
// The checker beside the block follows every accepted word and every result strobe and
// compares each result with the tracked table. This module only drives words and decides
// the outcome. A short directed run covers the empty table, extreme keys and values,
// update, hit, miss, the unused opcode, remove of the oldest and of the newest entry and
// remove of an absent key. The random part then works a small key pool through fill
// (until new keys are dropped on a full table), drain (down toward empty) and mixed
// segments, under three sender idling levels. The result side has no back-pressure,
// so only the sender idles.
module linear_key_value_table_test;

    localparam lkv_pkg::opcode_t OP_SPARE      = 2'd3;  // unused code, behaves as lookup
    localparam int               KEY_POOL_SIZE = 96;    // above capacity so drops occur
    localparam int               STALL_LIMIT   = 2000;
    localparam int               DRAIN_CYCLES  = 4;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           start     = 1'b0;
    lkv_pkg::cmd_t  cmd       = '0;
    logic           busy;
    logic           rsp_valid;
    lkv_pkg::rsp_t  rsp;
    int             fail_count;
    int             pending_count;
    int             idle_pct  = 0;
    int             quiet_cycles = 0;
    lkv_pkg::word_t key_pool [KEY_POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    linear_key_value_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    lkv_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || rsp_valid)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Hold the word on the bus until taken; return on the accepting edge.
    // busy is sampled at the falling edge, where it is stable.
    task automatic send_word(input lkv_pkg::opcode_t op, input lkv_pkg::word_t k,
                             input lkv_pkg::word_t v);
        lkv_pkg::cmd_t c;
        c.opcode = op;
        c.key    = k;
        c.value  = v;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Mostly pool keys so inserts, hits and removes meet; sometimes a fresh key.
    function automatic lkv_pkg::word_t pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic lkv_pkg::word_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return $urandom;
    endfunction

    // Issue a run of words with the given insert and remove shares; the rest look up.
    task automatic run_segment(input int count, input int ins_pct, input int rem_pct);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                send_word(lkv_pkg::OP_INSERT, pick_key(), pick_value());
            else if (r < ins_pct + rem_pct)
                send_word(lkv_pkg::OP_REMOVE, pick_key(), pick_value());
            else if ($urandom_range(0, 3) == 0)
                send_word(OP_SPARE, pick_key(), pick_value());
            else
                send_word(lkv_pkg::OP_LOOKUP, pick_key(), pick_value());
        end
    endtask

    initial
    begin
        int idle_levels [3];
        idle_levels = '{0, 87, 20};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start on the empty table.
        send_word(lkv_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // miss on empty
        send_word(lkv_pkg::OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);  // remove miss, empty
        send_word(OP_SPARE,           32'h0000_0005, 32'h0000_0000);  // unused code, miss
        send_word(lkv_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(lkv_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(lkv_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);  // update in place
        send_word(lkv_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(lkv_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // hit on a zero value
        send_word(OP_SPARE,           32'hFFFF_FFFF, 32'h0000_0000);  // unused code, hit
        send_word(lkv_pkg::OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_word(lkv_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);  // first slot, first in
        send_word(lkv_pkg::OP_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
        send_word(lkv_pkg::OP_REMOVE, 32'h0001_2345, 32'h0000_0000);  // absent key
        send_word(lkv_pkg::OP_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_word(lkv_pkg::OP_REMOVE, 32'h5A5A_5A5A, 32'h0000_0000);  // remove the last entry
        send_word(lkv_pkg::OP_REMOVE, 32'hA5A5_A5A5, 32'h0000_0000);
        send_word(lkv_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);  // back to empty
        send_word(lkv_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

        // Random: fill past capacity, drain toward empty, then mix, per idling level.
        foreach (idle_levels[p])
        begin
            idle_pct = idle_levels[p];
            run_segment(170, 88, 4);
            run_segment(150, 10, 85);
            run_segment(90, 35, 30);
        end
        idle_pct = 0;
        start <= 1'b0;

        // Wait out every outstanding result, then let any stray result show.
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/linear_key_value_table.sv
tb/lkv_table_checker.sv
tb/linear_key_value_table_test.sv
